[rtl/tbs_pkg.sv]
`timescale 1ns / 1ps

package tbs_pkg;

	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 128;

	localparam int COORD_W      = 17;
	localparam int FRAC_W       = 16;
	localparam int CHAN_W       = 16;
	localparam int CHANNELS     = 4;
	localparam int TAPS         = 4;
	localparam int INDEX_W      = 15;
	localparam int CFG_W        = 9;
	localparam int MAP_WIDTH_W  = 9;
	localparam int MAP_HEIGHT_W = 8;
	localparam int WT_W         = 33;
	localparam int PROD_W       = 48;
	localparam int SUM_W        = 50;

	localparam logic [COORD_W-1:0]      ONE_Q16        = 17'h10000;
	localparam logic [MAP_WIDTH_W-1:0]  MAP_WIDTH_RST  = 9'd256;
	localparam logic [MAP_HEIGHT_W-1:0] MAP_HEIGHT_RST = 8'd128;

	// tap order: (x0,y0), (x1,y0), (x0,y1), (x1,y1)
	localparam int TAP_00 = 0;
	localparam int TAP_01 = 1;
	localparam int TAP_10 = 2;
	localparam int TAP_11 = 3;

	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;
	localparam int CH_ALPHA = 3;

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_SAMPLE = 1'b1
	} op_t;

	typedef enum logic {
		MODE_NEAREST   = 1'b0,
		MODE_BILINEAR  = 1'b1
	} mode_t;

	typedef enum logic {
		REG_MAP_WIDTH  = 1'b0,
		REG_MAP_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef logic [CHANNELS-1:0][CHAN_W-1:0] texel_t;
	typedef texel_t [TAPS-1:0] quad_t;
	typedef logic [TAPS-1:0][WT_W-1:0] weights_t;

	typedef struct packed {
		op_t                operation;
		logic [INDEX_W-1:0] texel_index;
		logic [CHAN_W-1:0]  write_red;
		logic [CHAN_W-1:0]  write_green;
		logic [CHAN_W-1:0]  write_blue;
		logic [CHAN_W-1:0]  write_alpha;
		logic [COORD_W-1:0] coord_u;
		logic [COORD_W-1:0] coord_v;
		mode_t              sample_mode;
	} in_item_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_red;
		logic [CHAN_W-1:0] out_green;
		logic [CHAN_W-1:0] out_blue;
		logic [CHAN_W-1:0] out_alpha;
	} out_item_t;

	typedef struct packed {
		logic  valid;
		op_t   operation;
		mode_t sample_mode;
	} pipe_ctl_t;

endpackage

[rtl/tbs_addr.sv]
`timescale 1ns / 1ps

module tbs_addr #(
	parameter int MAX_WIDTH  = tbs_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = tbs_pkg::MAX_HEIGHT_DEF,
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  accept,
	input  tbs_pkg::in_item_t                     request,
	input  logic [tbs_pkg::MAP_WIDTH_W-1:0]       map_width,
	input  logic [tbs_pkg::MAP_HEIGHT_W-1:0]      map_height,
	output tbs_pkg::pipe_ctl_t                    ctl_s5,
	output logic                                  we_s5,
	output logic [AW-1:0]                         waddr_s5,
	output tbs_pkg::texel_t                       wdata_s5,
	output logic [tbs_pkg::TAPS-1:0][AW-1:0]      raddr_s5,
	output tbs_pkg::weights_t                     weights_s5
);

	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int XW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int YW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int PXW = tbs_pkg::COORD_W + WW;
	localparam int PYW = tbs_pkg::COORD_W + HW;
	localparam int BW  = YW + WW;
	localparam int FPW = 2 * tbs_pkg::COORD_W;
	localparam int WSW = tbs_pkg::WT_W + 2;

	logic [WW-1:0]                    w_c;
	logic [HW-1:0]                    h_c;
	logic [tbs_pkg::COORD_W-1:0]      u_c;
	logic [tbs_pkg::COORD_W-1:0]      v_c;

	tbs_pkg::pipe_ctl_t               ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic [tbs_pkg::INDEX_W-1:0]      idx_s1, idx_s2, idx_s3, idx_s4;
	tbs_pkg::texel_t                  texel_s1, texel_s2, texel_s3, texel_s4;

	logic [tbs_pkg::COORD_W-1:0]      u_s1, v_s1;
	logic [WW-1:0]                    w_s1, w_s2, w_s3;
	logic [HW-1:0]                    h_s1, h_s2;

	logic [PXW-1:0]                   px_s2;
	logic [PYW-1:0]                   py_s2;

	logic [WW:0]                      flx_c, xp1_c;
	logic [HW:0]                      fly_c, yp1_c;
	logic [WW-1:0]                    wm1_c;
	logic [HW-1:0]                    hm1_c;
	logic [XW-1:0]                    x0_c, x1_c;
	logic [YW-1:0]                    y0_c, y1_c;
	logic [tbs_pkg::COORD_W-1:0]      fx_c, fy_c;

	logic [XW-1:0]                    x0_s3, x1_s3, x0_s4, x1_s4;
	logic [YW-1:0]                    y0_s3, y1_s3;
	logic [tbs_pkg::COORD_W-1:0]      fx_s3, fy_s3;

	logic [tbs_pkg::COORD_W-1:0]      omx_c, omy_c;
	logic [BW-1:0]                    base0_s4, base1_s4;
	tbs_pkg::weights_t                weights_s4;
	logic                             idx_ok_s4;

	// size and coordinate clamps
	always_comb begin
		if (map_width == '0) begin
			w_c = WW'(1);
		end else if (32'(map_width) > 32'(MAX_WIDTH)) begin
			w_c = WW'(MAX_WIDTH);
		end else begin
			w_c = WW'(map_width);
		end
		if (map_height == '0) begin
			h_c = HW'(1);
		end else if (32'(map_height) > 32'(MAX_HEIGHT)) begin
			h_c = HW'(MAX_HEIGHT);
		end else begin
			h_c = HW'(map_height);
		end
		u_c = (request.coord_u > tbs_pkg::ONE_Q16) ? tbs_pkg::ONE_Q16 : request.coord_u;
		v_c = (request.coord_v > tbs_pkg::ONE_Q16) ? tbs_pkg::ONE_Q16 : request.coord_v;
	end

	// floor, edge clamp and fraction
	always_comb begin
		flx_c = px_s2[PXW-1:tbs_pkg::FRAC_W];
		wm1_c = w_s2 - WW'(1);
		x0_c  = (flx_c > (WW+1)'(wm1_c)) ? XW'(wm1_c) : XW'(flx_c);
		xp1_c = (WW+1)'(x0_c) + (WW+1)'(1);
		x1_c  = (xp1_c > (WW+1)'(wm1_c)) ? XW'(wm1_c) : XW'(xp1_c);
		fx_c  = tbs_pkg::COORD_W'(px_s2 - (PXW'(x0_c) << tbs_pkg::FRAC_W));

		fly_c = py_s2[PYW-1:tbs_pkg::FRAC_W];
		hm1_c = h_s2 - HW'(1);
		y0_c  = (fly_c > (HW+1)'(hm1_c)) ? YW'(hm1_c) : YW'(fly_c);
		yp1_c = (HW+1)'(y0_c) + (HW+1)'(1);
		y1_c  = (yp1_c > (HW+1)'(hm1_c)) ? YW'(hm1_c) : YW'(yp1_c);
		fy_c  = tbs_pkg::COORD_W'(py_s2 - (PYW'(y0_c) << tbs_pkg::FRAC_W));

		omx_c = tbs_pkg::ONE_Q16 - fx_s3;
		omy_c = tbs_pkg::ONE_Q16 - fy_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			we_s5  <= 1'b0;
		end else begin
			ctl_s1 <= '{valid: accept, operation: request.operation,
				sample_mode: request.sample_mode};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			we_s5  <= ctl_s4.valid && (ctl_s4.operation == tbs_pkg::OP_WRITE) && idx_ok_s4;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1   <= request.texel_index;
		texel_s1 <= {request.write_alpha, request.write_blue,
			request.write_green, request.write_red};
		u_s1     <= u_c;
		v_s1     <= v_c;
		w_s1     <= w_c;
		h_s1     <= h_c;

		idx_s2   <= idx_s1;
		texel_s2 <= texel_s1;
		w_s2     <= w_s1;
		h_s2     <= h_s1;
		px_s2    <= PXW'(u_s1) * PXW'(w_s1);
		py_s2    <= PYW'(v_s1) * PYW'(h_s1);

		idx_s3   <= idx_s2;
		texel_s3 <= texel_s2;
		w_s3     <= w_s2;
		x0_s3    <= x0_c;
		x1_s3    <= x1_c;
		y0_s3    <= y0_c;
		y1_s3    <= y1_c;
		fx_s3    <= fx_c;
		fy_s3    <= fy_c;

		idx_s4    <= idx_s3;
		idx_ok_s4 <= 32'(idx_s3) < 32'(DEPTH);
		texel_s4  <= texel_s3;
		x0_s4     <= x0_s3;
		x1_s4     <= x1_s3;
		base0_s4  <= BW'(y0_s3) * BW'(w_s3);
		base1_s4  <= BW'(y1_s3) * BW'(w_s3);
		weights_s4[tbs_pkg::TAP_00] <= tbs_pkg::WT_W'(FPW'(omx_c) * FPW'(omy_c));
		weights_s4[tbs_pkg::TAP_01] <= tbs_pkg::WT_W'(FPW'(fx_s3) * FPW'(omy_c));
		weights_s4[tbs_pkg::TAP_10] <= tbs_pkg::WT_W'(FPW'(omx_c) * FPW'(fy_s3));
		weights_s4[tbs_pkg::TAP_11] <= tbs_pkg::WT_W'(FPW'(fx_s3) * FPW'(fy_s3));

		waddr_s5   <= AW'(idx_s4);
		wdata_s5   <= texel_s4;
		weights_s5 <= weights_s4;
		raddr_s5[tbs_pkg::TAP_00] <= AW'(base0_s4 + BW'(x0_s4));
		raddr_s5[tbs_pkg::TAP_01] <= AW'(base0_s4 + BW'(x1_s4));
		raddr_s5[tbs_pkg::TAP_10] <= AW'(base1_s4 + BW'(x0_s4));
		raddr_s5[tbs_pkg::TAP_11] <= AW'(base1_s4 + BW'(x1_s4));
	end

	a_taps_in_map: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s3.valid |-> (x0_s3 <= x1_s3) && (WW'(x1_s3) < w_s3) && (y0_s3 <= y1_s3))
		else $error("texel taps outside the map");

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s3.valid |-> (fx_s3 <= tbs_pkg::ONE_Q16) && (fy_s3 <= tbs_pkg::ONE_Q16))
		else $error("fraction above one");

	a_weight_sum: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s4.valid |-> (WSW'(weights_s4[tbs_pkg::TAP_00]) + WSW'(weights_s4[tbs_pkg::TAP_01])
			+ WSW'(weights_s4[tbs_pkg::TAP_10]) + WSW'(weights_s4[tbs_pkg::TAP_11]))
			== (WSW'(1) << (2 * tbs_pkg::FRAC_W)))
		else $error("blend weights do not sum to one");

endmodule

[rtl/tbs_store.sv]
`timescale 1ns / 1ps

module tbs_store #(
	parameter int MAX_WIDTH  = tbs_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = tbs_pkg::MAX_HEIGHT_DEF,
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [AW-1:0]                    waddr,
	input  tbs_pkg::texel_t                  wdata,
	input  logic [tbs_pkg::TAPS-1:0][AW-1:0] raddr,
	output tbs_pkg::quad_t                   texels_s6
);

	// two copies, each with two read ports: upper row taps and lower row taps
	tbs_pkg::texel_t mem_top [DEPTH];
	tbs_pkg::texel_t mem_bot [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_top[waddr] <= wdata;
			mem_bot[waddr] <= wdata;
		end
		texels_s6[tbs_pkg::TAP_00] <= mem_top[raddr[tbs_pkg::TAP_00]];
		texels_s6[tbs_pkg::TAP_01] <= mem_top[raddr[tbs_pkg::TAP_01]];
		texels_s6[tbs_pkg::TAP_10] <= mem_bot[raddr[tbs_pkg::TAP_10]];
		texels_s6[tbs_pkg::TAP_11] <= mem_bot[raddr[tbs_pkg::TAP_11]];
	end

endmodule

[rtl/tbs_blend.sv]
`timescale 1ns / 1ps

module tbs_blend (
	input  logic               clk,
	input  logic               arst_n,
	input  tbs_pkg::pipe_ctl_t ctl_s5,
	input  tbs_pkg::weights_t  weights_s5,
	input  tbs_pkg::quad_t     texels_s6,
	output logic               done,
	output tbs_pkg::out_item_t result
);

	localparam int PMW = tbs_pkg::PROD_W + 1;

	tbs_pkg::pipe_ctl_t ctl_s6, ctl_s7;
	tbs_pkg::weights_t  wt_s6;
	logic [tbs_pkg::TAPS-1:0][tbs_pkg::CHANNELS-1:0][tbs_pkg::PROD_W-1:0] prod_s7;
	tbs_pkg::texel_t    near_s7;
	logic [tbs_pkg::SUM_W-1:0] sum_c [tbs_pkg::CHANNELS];
	tbs_pkg::texel_t    pick_c;
	logic               done_s8;
	tbs_pkg::out_item_t result_s8;

	always_comb begin
		for (int k = 0; k < tbs_pkg::CHANNELS; k++) begin
			sum_c[k] = tbs_pkg::SUM_W'(prod_s7[tbs_pkg::TAP_00][k])
				+ tbs_pkg::SUM_W'(prod_s7[tbs_pkg::TAP_01][k])
				+ tbs_pkg::SUM_W'(prod_s7[tbs_pkg::TAP_10][k])
				+ tbs_pkg::SUM_W'(prod_s7[tbs_pkg::TAP_11][k]);
			if (ctl_s7.sample_mode == tbs_pkg::MODE_BILINEAR) begin
				pick_c[k] = sum_c[k][2*tbs_pkg::FRAC_W +: tbs_pkg::CHAN_W];
			end else begin
				pick_c[k] = near_s7[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s6  <= '0;
			ctl_s7  <= '0;
			done_s8 <= 1'b0;
		end else begin
			ctl_s6  <= ctl_s5;
			ctl_s7  <= ctl_s6;
			done_s8 <= ctl_s7.valid && (ctl_s7.operation == tbs_pkg::OP_SAMPLE);
		end
	end

	always_ff @(posedge clk) begin
		wt_s6   <= weights_s5;
		near_s7 <= texels_s6[tbs_pkg::TAP_00];
		for (int t = 0; t < tbs_pkg::TAPS; t++) begin
			for (int k = 0; k < tbs_pkg::CHANNELS; k++) begin
				prod_s7[t][k] <= tbs_pkg::PROD_W'(PMW'(texels_s6[t][k]) * PMW'(wt_s6[t]));
			end
		end
		result_s8.out_red   <= pick_c[tbs_pkg::CH_RED];
		result_s8.out_green <= pick_c[tbs_pkg::CH_GREEN];
		result_s8.out_blue  <= pick_c[tbs_pkg::CH_BLUE];
		result_s8.out_alpha <= pick_c[tbs_pkg::CH_ALPHA];
	end

	assign done   = done_s8;
	assign result = result_s8;

endmodule

[rtl/texture_bilinear_sampler.sv]
`timescale 1ns / 1ps
// Throughput: one transaction per cycle, writes and samples alike; writes give no result.
// The four texel fetches use two copies of the texture store, two read ports each.
// Reset clears the pipeline and sets the map to 256 x 128; texture contents stay undefined.
// busy is high only during reset; done is a one-cycle strobe that the receiver cannot stall.

module texture_bilinear_sampler #(
	parameter int MAX_WIDTH  = tbs_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = tbs_pkg::MAX_HEIGHT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  tbs_pkg::in_item_t           request,
	output logic                        done,
	output tbs_pkg::out_item_t          result,
	input  logic                        cfg_we,
	input  tbs_pkg::cfg_reg_t           cfg_index,
	input  logic [tbs_pkg::CFG_W-1:0]   cfg_data
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LAT   = 8;

	logic [tbs_pkg::MAP_WIDTH_W-1:0]  map_width_q;
	logic [tbs_pkg::MAP_HEIGHT_W-1:0] map_height_q;
	logic                             accept;

	tbs_pkg::pipe_ctl_t               ctl_s5;
	logic                             we_s5;
	logic [AW-1:0]                    waddr_s5;
	tbs_pkg::texel_t                  wdata_s5;
	logic [tbs_pkg::TAPS-1:0][AW-1:0] raddr_s5;
	tbs_pkg::weights_t                weights_s5;
	tbs_pkg::quad_t                   texels_s6;

	assign busy   = ~arst_n;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q  <= tbs_pkg::MAP_WIDTH_RST;
			map_height_q <= tbs_pkg::MAP_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tbs_pkg::REG_MAP_WIDTH: begin
					map_width_q <= cfg_data[tbs_pkg::MAP_WIDTH_W-1:0];
				end
				tbs_pkg::REG_MAP_HEIGHT: begin
					map_height_q <= cfg_data[tbs_pkg::MAP_HEIGHT_W-1:0];
				end
			endcase
		end
	end

	tbs_addr #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_addr (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.request    (request),
		.map_width  (map_width_q),
		.map_height (map_height_q),
		.ctl_s5     (ctl_s5),
		.we_s5      (we_s5),
		.waddr_s5   (waddr_s5),
		.wdata_s5   (wdata_s5),
		.raddr_s5   (raddr_s5),
		.weights_s5 (weights_s5)
	);

	tbs_store #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_store (
		.clk       (clk),
		.we        (we_s5),
		.waddr     (waddr_s5),
		.wdata     (wdata_s5),
		.raddr     (raddr_s5),
		.texels_s6 (texels_s6)
	);

	tbs_blend u_blend (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl_s5     (ctl_s5),
		.weights_s5 (weights_s5),
		.texels_s6  (texels_s6),
		.done       (done),
		.result     (result)
	);

	a_done_has_sample: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && (request.operation == tbs_pkg::OP_SAMPLE), LAT))
		else $error("result without a sample transaction");

	a_sample_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (request.operation == tbs_pkg::OP_SAMPLE)) |-> ##LAT done)
		else $error("sample transaction lost");

endmodule
